>>> src/tpma_pkg.sv
// Shared types, constants and the control program of the timed priority mode arbiter.
`timescale 1ns / 1ps
`default_nettype none

package tpma_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 16;
  localparam int unsigned MODE_SLOTS_DEF = 8;

  localparam int unsigned CFG_W  = 64;
  localparam int unsigned CFG_IW = 1;
  localparam logic [CFG_IW-1:0] REG_MODE_COUNT = 1'b0;
  localparam logic [CFG_IW-1:0] REG_PRIORITY   = 1'b1;

  localparam logic signed [3:0] NO_MODE = -4'sd1;

  typedef enum logic [2:0] {
    OP_ACT   = 3'd0,
    OP_TACT  = 3'd1,
    OP_DEACT = 3'd2,
    OP_TICK  = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  typedef struct packed {
    logic [7:0]  mode;
    logic        pers;
    logic [31:0] end_ms;
  } entry_t;

  // Control word bits that drive the datapath.
  typedef struct packed {
    logic latch;
    logic find;
    logic compact;
    logic append;
    logic commit;
    logic clear;
    logic strobe;
  } ctl_t;

  typedef struct packed {
    logic scan_done;
  } sts_t;

  typedef enum logic [2:0] {
    SEQ_DISPATCH = 3'b001,
    SEQ_LOOP     = 3'b010,
    SEQ_GOTO     = 3'b100
  } seq_e;

  typedef logic [2:0] upc_t;

  localparam upc_t U_IDLE    = 3'd0;
  localparam upc_t U_FIND    = 3'd1;
  localparam upc_t U_APPEND  = 3'd2;
  localparam upc_t U_COMPACT = 3'd3;
  localparam upc_t U_COMMIT  = 3'd4;
  localparam upc_t U_DONE    = 3'd5;
  localparam upc_t U_CLEAR   = 3'd6;

  typedef struct packed {
    ctl_t ctl;
    seq_e seq;
    upc_t target;
  } uword_t;

  // The program: one word per step.
  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    w = '{ctl: '0, seq: SEQ_GOTO, target: U_IDLE};
    case (pc)
      U_IDLE: begin
        w.ctl.latch = 1'b1;
        w.seq       = SEQ_DISPATCH;
        w.target    = U_IDLE;
      end
      U_FIND: begin
        w.ctl.find = 1'b1;
        w.seq      = SEQ_LOOP;
        w.target   = U_APPEND;
      end
      U_APPEND: begin
        w.ctl.append = 1'b1;
        w.target     = U_DONE;
      end
      U_COMPACT: begin
        w.ctl.compact = 1'b1;
        w.seq         = SEQ_LOOP;
        w.target      = U_COMMIT;
      end
      U_COMMIT: begin
        w.ctl.commit = 1'b1;
        w.target     = U_DONE;
      end
      U_DONE: begin
        w.ctl.strobe = 1'b1;
        w.target     = U_IDLE;
      end
      U_CLEAR: begin
        w.ctl.clear = 1'b1;
        w.target    = U_DONE;
      end
      default: begin
        w.target = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> src/tpma_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tpma_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> src/tpma_useq.sv
// Microcode sequencer: step counter, program table and jump logic.
`timescale 1ns / 1ps
`default_nettype none

module tpma_useq
  import tpma_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [2:0] opcode_i,
  input  wire sts_t       sts_i,
  output ctl_t            ctl_o,
  output logic            busy_o
);

  upc_t   upc_q, upc_d;
  uword_t word;

  assign word = ucode(upc_q);

  always_comb begin
    ctl_o       = word.ctl;
    ctl_o.latch = word.ctl.latch & start_i;
  end

  assign busy_o = (upc_q != U_IDLE);

  always_comb begin
    upc_d = upc_q;
    case (word.seq)
      SEQ_DISPATCH: begin
        if (start_i) begin
          case (op_e'(opcode_i))
            OP_ACT, OP_TACT:  upc_d = U_FIND;
            OP_DEACT, OP_TICK: upc_d = U_COMPACT;
            OP_CLEAR:         upc_d = U_CLEAR;
            default:          upc_d = U_DONE;
          endcase
        end else begin
          upc_d = word.target;
        end
      end
      SEQ_LOOP: begin
        if (sts_i.scan_done) begin
          upc_d = word.target;
        end
      end
      SEQ_GOTO: begin
        upc_d = word.target;
      end
      default: begin
        upc_d = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  // The result strobe lasts one cycle and returns the sequencer to idle.
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.strobe |=> !ctl_o.strobe && !busy_o)
    else $error("result strobe not followed by idle");

  // A request is taken only in idle.
  a_latch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.latch |-> !busy_o && start_i)
    else $error("request latched while busy");

endmodule

`default_nettype wire

>>> src/tpma_dpath.sv
// Datapath: entry list scan, compaction, append, priority pick and result registers.
`timescale 1ns / 1ps
`default_nettype none

module tpma_dpath
  import tpma_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF,
  parameter int unsigned MODE_SLOTS = MODE_SLOTS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctl_t              ctl_i,
  output sts_t                   sts_o,
  input  wire logic [2:0]        opcode_i,
  input  wire logic [7:0]        mode_index_i,
  input  wire logic [31:0]       now_ms_i,
  input  wire logic [31:0]       duration_ms_i,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_IW-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  output logic signed [3:0]      effective_mode_o,
  output logic                   changed_o,
  output logic                   dropped_o
);

  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
  localparam logic [3:0]    SLOTS_C = 4'(MODE_SLOTS);

  // Configuration.
  logic [3:0]       mode_count_q;
  logic [CFG_W-1:0] prio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_count_q <= '0;
      prio_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE_COUNT: mode_count_q <= cfg_wdata_i[3:0];
        REG_PRIORITY:   prio_q       <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // Latched request.
  op_e         op_q;
  logic [7:0]  mode_q;
  logic [31:0] now_q;
  logic [31:0] end_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      op_q   <= op_e'(opcode_i);
      mode_q <= mode_index_i;
      now_q  <= now_ms_i;
      end_q  <= now_ms_i + duration_ms_i;
    end
  end

  // Scan state.
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      r_q, r_d;
  logic [CW-1:0]      w_q, w_d;
  logic [AW-1:0]      ev_q, ev_d;
  logic               pend_q, pend_d;
  logic               found_q, found_d;
  logic signed [3:0]  best_q, best_d;
  logic [7:0]         bprio_q, bprio_d;
  logic signed [3:0]  last_q, last_d;
  logic               changed_q, changed_d;
  logic               dropped_q, dropped_d;

  // Memory port.
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  entry_t        rdata;
  logic [$bits(entry_t)-1:0] rdata_raw;

  tpma_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (r_q[AW-1:0]),
    .rdata_o (rdata_raw)
  );

  assign rdata = entry_t'(rdata_raw);

  logic       more;
  logic       match;
  logic       keep;
  logic [3:0] limit;
  logic       valid_mode;
  logic [7:0] prio;

  assign more  = (r_q < count_q);
  assign limit = (mode_count_q > SLOTS_C) ? SLOTS_C : mode_count_q;
  assign valid_mode = (rdata.mode < {4'd0, limit});
  assign prio  = prio_q[{rdata.mode[2:0], 3'b000} +: 8];

  always_comb begin
    match = 1'b0;
    if (rdata.mode == mode_q) begin
      match = (op_q == OP_ACT) || !rdata.pers;
    end
  end

  always_comb begin
    if (op_q == OP_DEACT) begin
      keep = (rdata.mode != mode_q);
    end else begin
      keep = rdata.pers || (now_q < rdata.end_ms);
    end
  end

  always_comb begin
    sts_o.scan_done = !pend_q && !more;
    if (ctl_i.find && pend_q && match) begin
      sts_o.scan_done = 1'b1;
    end
  end

  always_comb begin
    count_d   = count_q;
    r_d       = r_q;
    w_d       = w_q;
    ev_d      = ev_q;
    pend_d    = 1'b0;
    found_d   = found_q;
    best_d    = best_q;
    bprio_d   = bprio_q;
    last_d    = last_q;
    changed_d = changed_q;
    dropped_d = dropped_q;
    we        = 1'b0;
    waddr     = ev_q;
    wdata     = rdata;

    if (ctl_i.latch) begin
      r_d       = '0;
      w_d       = '0;
      found_d   = 1'b0;
      best_d    = NO_MODE;
      bprio_d   = '0;
      changed_d = 1'b0;
      dropped_d = 1'b0;
    end

    // One read is issued per cycle; the entry returns in the next cycle.
    if ((ctl_i.find || ctl_i.compact) && more) begin
      pend_d = 1'b1;
      r_d    = r_q + CW'(1);
      ev_d   = r_q[AW-1:0];
    end

    if (ctl_i.find && pend_q && match) begin
      found_d = 1'b1;
      we      = 1'b1;
      waddr   = ev_q;
      if (op_q == OP_ACT) begin
        wdata.pers   = 1'b1;
        wdata.end_ms = '0;
      end else if (end_q > rdata.end_ms) begin
        wdata.end_ms = end_q;
      end
    end

    if (ctl_i.compact && pend_q && keep) begin
      we    = 1'b1;
      waddr = w_q[AW-1:0];
      w_d   = w_q + CW'(1);
      // The earliest entry keeps a tie.
      if ((op_q == OP_TICK) && valid_mode &&
          ((best_q == NO_MODE) || (prio > bprio_q))) begin
        best_d  = signed'({1'b0, rdata.mode[2:0]});
        bprio_d = prio;
      end
    end

    if (ctl_i.append && !found_q) begin
      if (count_q < DEPTH_C) begin
        we      = 1'b1;
        waddr   = count_q[AW-1:0];
        wdata   = '{mode: mode_q, pers: (op_q == OP_ACT),
                    end_ms: ((op_q == OP_ACT) ? 32'd0 : end_q)};
        count_d = count_q + CW'(1);
      end else begin
        dropped_d = 1'b1;
      end
    end

    if (ctl_i.commit) begin
      count_d = w_q;
      if (op_q == OP_TICK) begin
        changed_d = (best_q != last_q);
        last_d    = best_q;
      end
    end

    if (ctl_i.clear) begin
      count_d = '0;
      last_d  = NO_MODE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      r_q       <= '0;
      w_q       <= '0;
      ev_q      <= '0;
      pend_q    <= 1'b0;
      found_q   <= 1'b0;
      best_q    <= NO_MODE;
      bprio_q   <= '0;
      last_q    <= NO_MODE;
      changed_q <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      r_q       <= r_d;
      w_q       <= w_d;
      ev_q      <= ev_d;
      pend_q    <= pend_d;
      found_q   <= found_d;
      best_q    <= best_d;
      bprio_q   <= bprio_d;
      last_q    <= last_d;
      changed_q <= changed_d;
      dropped_q <= dropped_d;
    end
  end

  assign effective_mode_o = last_q;
  assign changed_o        = changed_q;
  assign dropped_o        = dropped_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("entry count beyond list depth");

  // Compaction never writes ahead of what it has read.
  a_write_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.compact |-> w_q <= r_q)
    else $error("compaction write pointer ahead of read pointer");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(dropped_q) |-> $past(count_q) == DEPTH_C)
    else $error("append dropped while list had room");

endmodule

`default_nettype wire

>>> src/timed_priority_mode_arbiter_core.sv
// Top level of the timed priority mode arbiter: sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// A request (opcode, mode_index, now_ms, duration_ms) is taken at a rising
// edge with start_i high and busy_o low. busy_o stays high while the request
// is worked on. Exactly one result per request appears on effective_mode_o,
// changed_o and dropped_o, marked by done_o for one cycle; it cannot be held
// off, so the receiver must take it in that cycle.
// Activate, timed activate, deactivate and tick walk the entry list one entry
// per cycle through the single read port of the list memory; clear and an
// undefined opcode do not walk it. A new request is taken only once the
// sequencer is back in idle.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) land at once and
// belong to idle periods.
// Reset empties the list and sets the effective mode to minus one; the list
// memory itself needs no clearing pass.

module timed_priority_mode_arbiter_core
  import tpma_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF,
  parameter int unsigned MODE_SLOTS = MODE_SLOTS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [2:0]        opcode_i,
  input  wire logic [7:0]        mode_index_i,
  input  wire logic [31:0]       now_ms_i,
  input  wire logic [31:0]       duration_ms_i,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_IW-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  output logic                   done_o,
  output logic signed [3:0]      effective_mode_o,
  output logic                   changed_o,
  output logic                   dropped_o
);

  ctl_t ctl;
  sts_t sts;

  tpma_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .ctl_o    (ctl),
    .busy_o   (busy_o)
  );

  tpma_dpath #(
    .LIST_DEPTH (LIST_DEPTH),
    .MODE_SLOTS (MODE_SLOTS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .opcode_i         (opcode_i),
    .mode_index_i     (mode_index_i),
    .now_ms_i         (now_ms_i),
    .duration_ms_i    (duration_ms_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .effective_mode_o (effective_mode_o),
    .changed_o        (changed_o),
    .dropped_o        (dropped_o)
  );

  assign done_o = ctl.strobe;

endmodule

`default_nettype wire

>>> tb/tpma_checker.sv
// Checker for the timed priority mode arbiter: predicts each request and compares results.
`timescale 1ns / 1ps
`default_nettype none

module tpma_checker
  import tpma_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              busy_i,
  input  wire logic [2:0]        opcode_i,
  input  wire logic [7:0]        mode_index_i,
  input  wire logic [31:0]       now_ms_i,
  input  wire logic [31:0]       duration_ms_i,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_IW-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  input  wire logic              done_i,
  input  wire logic signed [3:0] effective_mode_i,
  input  wire logic              changed_i,
  input  wire logic              dropped_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o
);

  typedef struct packed {
    logic signed [3:0] eff;
    logic              chg;
    logic              drop;
  } outcome_t;

  // Model copy of the mode list, the shown mode and both registers.
  logic [7:0]        slot_mode [LIST_DEPTH_DEF];
  logic              slot_pers [LIST_DEPTH_DEF];
  logic [31:0]       slot_end  [LIST_DEPTH_DEF];
  int unsigned       slot_count;
  logic signed [3:0] shown_mode;
  logic [3:0]        mode_count_reg;
  logic [63:0]       priority_reg;

  outcome_t    expected_outcomes[$];
  int unsigned mismatches = 0;

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic bit append_slot(input logic [7:0] m, input logic pers,
                                     input logic [31:0] expiry);
    if (slot_count >= LIST_DEPTH_DEF) begin
      return 1'b0;
    end
    slot_mode[slot_count] = m;
    slot_pers[slot_count] = pers;
    slot_end[slot_count]  = expiry;
    slot_count++;
    return 1'b1;
  endfunction

  task automatic predict_request(input logic [2:0] op, input logic [7:0] m,
                                 input logic [31:0] now, input logic [31:0] dur,
                                 output outcome_t res);
    int unsigned       w;
    int unsigned       limit;
    bit                hit;
    bit                picked;
    logic [31:0]       expiry;
    logic [7:0]        best_prio;
    logic [7:0]        prio;
    logic signed [3:0] best;
    res  = '{eff: shown_mode, chg: 1'b0, drop: 1'b0};
    hit  = 1'b0;
    case (op)
      OP_ACT: begin
        for (int unsigned i = 0; i < slot_count && !hit; i++) begin
          if (slot_mode[i] == m) begin
            slot_pers[i] = 1'b1;
            slot_end[i]  = '0;
            hit          = 1'b1;
          end
        end
        if (!hit) begin
          res.drop = !append_slot(m, 1'b1, '0);
        end
      end
      OP_TACT: begin
        expiry = now + dur;
        for (int unsigned i = 0; i < slot_count && !hit; i++) begin
          if (slot_mode[i] == m && !slot_pers[i]) begin
            if (expiry > slot_end[i]) begin
              slot_end[i] = expiry;
            end
            hit = 1'b1;
          end
        end
        if (!hit) begin
          res.drop = !append_slot(m, 1'b0, expiry);
        end
      end
      OP_DEACT: begin
        w = 0;
        for (int unsigned i = 0; i < slot_count; i++) begin
          if (slot_mode[i] != m) begin
            slot_mode[w] = slot_mode[i];
            slot_pers[w] = slot_pers[i];
            slot_end[w]  = slot_end[i];
            w++;
          end
        end
        slot_count = w;
      end
      OP_TICK: begin
        w = 0;
        for (int unsigned i = 0; i < slot_count; i++) begin
          if (slot_pers[i] || now < slot_end[i]) begin
            slot_mode[w] = slot_mode[i];
            slot_pers[w] = slot_pers[i];
            slot_end[w]  = slot_end[i];
            w++;
          end
        end
        slot_count = w;
        limit     = (mode_count_reg > MODE_SLOTS_DEF) ? MODE_SLOTS_DEF : mode_count_reg;
        best      = NO_MODE;
        best_prio = '0;
        picked    = 1'b0;
        // A strictly higher priority is needed to displace an earlier entry.
        for (int unsigned i = 0; i < slot_count; i++) begin
          if (slot_mode[i] < limit) begin
            prio = priority_reg[8*slot_mode[i][2:0] +: 8];
            if (!picked || prio > best_prio) begin
              best      = $signed({1'b0, slot_mode[i][2:0]});
              best_prio = prio;
              picked    = 1'b1;
            end
          end
        end
        if (best != shown_mode) begin
          shown_mode = best;
          res.chg    = 1'b1;
        end
        res.eff = shown_mode;
      end
      OP_CLEAR: begin
        slot_count = 0;
        shown_mode = NO_MODE;
        res.eff    = NO_MODE;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    outcome_t made;
    if (!rst_ni) begin
      slot_count     = 0;
      shown_mode     = NO_MODE;
      mode_count_reg = '0;
      priority_reg   = '0;
      mismatches     = 0;
      expected_outcomes.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (done_i) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = expected_outcomes.pop_front();
          if (effective_mode_i !== want.eff) begin
            report_mismatch($sformatf("effective_mode got %0d want %0d",
                                      effective_mode_i, want.eff));
          end
          if (changed_i !== want.chg) begin
            report_mismatch($sformatf("changed got %b want %b", changed_i, want.chg));
          end
          if (dropped_i !== want.drop) begin
            report_mismatch($sformatf("dropped got %b want %b", dropped_i, want.drop));
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MODE_COUNT) begin
          mode_count_reg = cfg_wdata_i[3:0];
        end else if (cfg_idx_i == REG_PRIORITY) begin
          priority_reg = cfg_wdata_i;
        end
      end
      if (start_i && !busy_i) begin
        predict_request(opcode_i, mode_index_i, now_ms_i, duration_ms_i, made);
        expected_outcomes = {expected_outcomes, made};
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_outcomes.size();
    end
  end

endmodule

`default_nettype wire

>>> tb/timed_priority_mode_arbiter_core_tb.sv
// Testbench top for the timed priority mode arbiter: request stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none

module timed_priority_mode_arbiter_core_tb;
  import tpma_pkg::*;

  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned PHASE_REQUESTS  = 130;
  localparam int unsigned QUIET_REQUESTS  = 100;
  localparam logic [2:0]  OP_UNUSED_FIRST = OP_CLEAR + 3'd1;
  localparam logic [2:0]  OP_UNUSED_LAST  = 3'd7;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              start_i       = 1'b0;
  logic [2:0]        opcode_i      = OP_TICK;
  logic [7:0]        mode_index_i  = '0;
  logic [31:0]       now_ms_i      = '0;
  logic [31:0]       duration_ms_i = '0;
  logic              cfg_we_i      = 1'b0;
  logic [CFG_IW-1:0] cfg_idx_i     = REG_MODE_COUNT;
  logic [CFG_W-1:0]  cfg_wdata_i   = '0;
  wire logic              busy_o;
  wire logic              done_o;
  wire logic signed [3:0] effective_mode_o;
  wire logic              changed_o;
  wire logic              dropped_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned stall_cycles = 0;
  logic [31:0] clock_ms     = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  timed_priority_mode_arbiter_core uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .mode_index_i, .now_ms_i,
    .duration_ms_i, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .done_o,
    .effective_mode_o, .changed_o, .dropped_o
  );

  tpma_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .opcode_i, .mode_index_i, .now_ms_i,
    .duration_ms_i, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .done_i(done_o),
    .effective_mode_i(effective_mode_o), .changed_i(changed_o), .dropped_i(dropped_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Any cycle without an accepted request or a result counts toward the stall limit.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timed_priority_mode_arbiter_core_tb: FAIL");
        $finish;
      end
    end
  end

  // Holds start high until the request is taken; the caller lowers it.
  task automatic send_request(input logic [2:0] op, input logic [7:0] m,
                              input logic [31:0] now, input logic [31:0] dur);
    start_i       <= 1'b1;
    opcode_i      <= op;
    mode_index_i  <= m;
    now_ms_i      <= now;
    duration_ms_i <= dur;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic pause_requests(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy_o);
  endtask

  // Both registers are written back to back once the block has gone quiet.
  task automatic configure(input logic [3:0] count, input logic [63:0] prio);
    drain_results();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_MODE_COUNT;
    cfg_wdata_i <= {$urandom, 28'($urandom_range(0, 'hFFF_FFFF)), count};
    @(posedge clk_i);
    cfg_idx_i   <= REG_PRIORITY;
    cfg_wdata_i <= prio;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly coherent traffic on a small pool of modes with a moving clock;
  // the fill-heavy mix appends enough distinct modes to run the list full.
  task automatic random_request(input bit fill_heavy);
    int unsigned roll;
    logic [2:0]  op;
    logic [7:0]  m;
    logic [31:0] dur;
    roll = $urandom_range(0, 99);
    if (fill_heavy) begin
      if (roll < 45)      op = OP_ACT;
      else if (roll < 85) op = OP_TACT;
      else if (roll < 99) op = OP_TICK;
      else                op = OP_CLEAR;
      m = 8'($urandom_range(0, 30));
    end else begin
      if (roll < 25)      op = OP_ACT;
      else if (roll < 55) op = OP_TACT;
      else if (roll < 67) op = OP_DEACT;
      else if (roll < 93) op = OP_TICK;
      else if (roll < 96) op = OP_CLEAR;
      else                op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      m = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 11))
                                       : 8'($urandom_range(0, 255));
    end
    roll = $urandom_range(0, 99);
    if (roll < 2)      clock_ms = $urandom;
    else if (roll < 4) clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
    else               clock_ms = clock_ms + $urandom_range(0, 40);
    roll = $urandom_range(0, 99);
    if (roll < 80)      dur = $urandom_range(0, 300);
    else if (roll < 90) dur = $urandom;
    else if (roll < 95) dur = '0;
    else                dur = '1;
    if ($urandom_range(0, 99) < 3) begin
      send_request(3'($urandom_range(0, 7)), 8'($urandom), $urandom, $urandom);
    end else begin
      send_request(op, m, clock_ms, dur);
    end
  endtask

  initial begin
    int unsigned issued;
    logic [3:0]  count;
    logic [63:0] prio;
    issued = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Modes 2 and 6 share the top priority so the earlier entry must win.
    configure(4'd8, 64'h00_5A_32_28_1E_5A_14_0A);
    send_request(OP_TICK, 8'd0, 32'd0, 32'd0);
    send_request(OP_ACT, 8'd6, 32'd0, 32'd0);
    send_request(OP_ACT, 8'd255, 32'd0, 32'd0);
    send_request(OP_TACT, 8'd2, 32'd100, 32'd50);
    send_request(OP_TACT, 8'd2, 32'd100, 32'd10);
    send_request(OP_TICK, 8'd0, 32'd120, 32'd0);
    send_request(OP_DEACT, 8'd6, 32'd0, 32'd0);
    send_request(OP_TICK, 8'd0, 32'd149, 32'd0);
    send_request(OP_TICK, 8'd0, 32'd150, 32'd0);
    send_request(OP_TACT, 8'd0, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_request(OP_TACT, 8'd7, 32'hFFFF_FFF0, 32'h0000_0020);
    send_request(OP_ACT, 8'd0, 32'd0, 32'd0);
    send_request(OP_TICK, 8'd0, 32'hFFFF_FFFF, 32'd0);
    for (int code = OP_UNUSED_FIRST; code <= OP_UNUSED_LAST; code++) begin
      send_request(3'(code), 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    end
    send_request(OP_CLEAR, 8'd0, 32'd0, 32'd0);
    send_request(OP_TICK, 8'd0, 32'd0, 32'd0);

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin count = 4'd8;  prio = {$urandom, $urandom}; end
        1: begin count = 4'd0;  prio = '0; end
        2: begin count = 4'd15; prio = '1; end
        3: begin count = 4'($urandom_range(1, 7)); prio = {$urandom, $urandom}; end
        4: begin
          count = 4'($urandom_range(0, 15));
          prio  = {$urandom, $urandom} & 64'h0303_0303_0303_0303;
        end
        default: begin count = 4'd8; prio = {$urandom, $urandom}; end
      endcase
      configure(count, prio);
      for (int unsigned n = 0; n < PHASE_REQUESTS; n++) begin
        if (issued < PHASES * PHASE_REQUESTS - QUIET_REQUESTS && $urandom_range(0, 99) < 20) begin
          pause_requests($urandom_range(1, 5));
        end
        random_request(phase == 2 || phase == 3);
        issued++;
      end
    end

    drain_results();
    repeat (25) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("timed_priority_mode_arbiter_core_tb: PASS");
    end else begin
      $display("timed_priority_mode_arbiter_core_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
